// ===== sv/tad_pkg.sv =====
package tad_pkg;

	// pipeline geometry
	localparam int CORDIC_STAGES = 16;
	localparam int STAGE_W       = 5;
	localparam int XW            = 27;
	localparam int ZW            = 18;
	localparam int DIV_STEPS     = 19;
	localparam int REM_W         = 14;
	localparam int OUT_W         = 19;

	// angles in radians * 2^14
	localparam logic signed [ZW-1:0] ANG_PI      = 18'sd51472;
	localparam logic signed [ZW-1:0] ANG_TWO_PI  = 18'sd102944;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 18'sd25736;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic valid;
		logic kind;
		logic roll_zero;
		logic pitch_zero;
	} tag_t;

	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [DIV_STEPS-1:0] num;
		logic [DIV_STEPS-1:0] quo;
		logic [REM_W-1:0]     dvs;
		logic                 neg;
	} div_t;

	// round(atan(2^-i) * 2^14)
	function automatic logic signed [ZW-1:0] atan_tab(input logic [STAGE_W-1:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:    r = 18'sd12868;
			5'd1:    r = 18'sd7596;
			5'd2:    r = 18'sd4014;
			5'd3:    r = 18'sd2037;
			5'd4:    r = 18'sd1023;
			5'd5:    r = 18'sd512;
			5'd6:    r = 18'sd256;
			5'd7:    r = 18'sd128;
			5'd8:    r = 18'sd64;
			5'd9:    r = 18'sd32;
			5'd10:   r = 18'sd16;
			5'd11:   r = 18'sd8;
			5'd12:   r = 18'sd4;
			5'd13:   r = 18'sd2;
			5'd14:   r = 18'sd1;
			default: r = 18'sd0;
		endcase
		return r;
	endfunction

	// constant sets selected by pad kind
	function automatic logic [15:0] set_margin(input logic kind);
		return kind ? 16'd2860 : 16'd1430;
	endfunction

	function automatic logic [15:0] set_rpos(input logic kind);
		return kind ? 16'd11438 : 16'd7149;
	endfunction

	function automatic logic [15:0] set_rneg(input logic kind);
		return kind ? 16'd6434 : 16'd7149;
	endfunction

	function automatic logic signed [ZW-1:0] set_base(input logic kind);
		return kind ? 18'sd12868 : 18'sd2860;
	endfunction

	// scale by 256, pre-rotate into the right half plane
	function automatic cordic_t cordic_init(input logic signed [16:0] yi,
			input logic signed [16:0] xi);
		cordic_t r;
		logic signed [XW-1:0] xe;
		logic signed [XW-1:0] ye;
		xe = XW'(xi) <<< 8;
		ye = XW'(yi) <<< 8;
		r.x = xe;
		r.y = ye;
		r.z = '0;
		if (xe < 0) begin
			if (ye >= 0) begin
				r.x = ye;
				r.y = -xe;
				r.z = ANG_HALF_PI;
			end else begin
				r.x = -ye;
				r.y = xe;
				r.z = -ANG_HALF_PI;
			end
		end
		return r;
	endfunction

	// dead zone front end: magnitude, margin, divisor setup
	function automatic div_t dz_setup(input logic signed [ZW-1:0] a, input logic kind,
			input logic use_neg_range);
		div_t r;
		logic [ZW-1:0] mag;
		logic [15:0]   margin;
		logic [15:0]   rng;
		logic [15:0]   diff;
		logic [29:0]   num;
		mag    = a[ZW-1] ? ZW'(-a) : ZW'(a);
		margin = set_margin(kind);
		rng    = (use_neg_range && a[ZW-1]) ? set_rneg(kind) : set_rpos(kind);
		diff   = (mag[15:0] < margin) ? 16'd0 : mag[15:0] - margin;
		num    = {diff, 14'd0};
		r.rem  = REM_W'(num[29:DIV_STEPS]);
		r.num  = num[DIV_STEPS-1:0];
		r.quo  = '0;
		r.dvs  = REM_W'(rng - margin);
		r.neg  = a[ZW-1];
		return r;
	endfunction

endpackage

// ===== sv/tad_cordic_cell.sv =====
module tad_cordic_cell import tad_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [STAGE_W-1:0]  stage,
	input  cordic_t             d,
	output cordic_t             q
);

	cordic_t cell_q;
	cordic_t nxt;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;

	// one vectoring micro-rotation, floor shifts
	always_comb begin
		xs = d.x >>> stage;
		ys = d.y >>> stage;
		if (!d.y[XW-1]) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + atan_tab(stage);
		end else begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - atan_tab(stage);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;

endmodule

// ===== sv/tad_div_cell.sv =====
module tad_div_cell import tad_pkg::*; (
	input  logic clk,
	input  logic en,
	input  div_t d,
	output div_t q
);

	div_t cell_q;
	div_t nxt;
	logic [REM_W:0] t;
	logic           ge;

	// one restoring division step
	always_comb begin
		t       = {d.rem, d.num[DIV_STEPS-1]};
		ge      = t >= {1'b0, d.dvs};
		nxt     = d;
		nxt.rem = ge ? REM_W'(t - {1'b0, d.dvs}) : REM_W'(t);
		nxt.num = {d.num[DIV_STEPS-2:0], 1'b0};
		nxt.quo = {d.quo[DIV_STEPS-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;

endmodule

// ===== sv/tilt_to_axis_dead_zone.sv =====
// Tilt to stick-axis converter with dead zone.
// Input stream: one beat per accelerometer sample, tdata = accel_x, accel_y,
// accel_z (16-bit signed Q4.12 each). Output stream: one beat per sample,
// tdata = axis_x, axis_y (19-bit signed Q4.14, saturating).
// cfg_wen/cfg_wdata write pad_kind (constant set select); write only while idle.
// Pipeline: one prep stage, one CORDIC cell per iteration for roll and for
// pitch (16 cells each), an angle stage, a dead-zone stage, 19 restoring divider
// cells per axis and an output register.
// Throughput: one beat per cycle while the output is not stalled; the pipeline advances as a whole.
// When the receiver stalls with a beat held in the output register, the
// whole pipeline freezes and s_axis_tready drops; nothing is lost.
// Reset clears all valid bits and pad_kind to the main controller set.
module tilt_to_axis_dead_zone import tad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // accel_x, accel_y, accel_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // axis_x, axis_y, 2 zero bits
	input  logic        cfg_wen,
	input  logic        cfg_wdata
);

	logic en;
	logic pad_kind_q;

	logic signed [15:0] ax, ay, az;
	logic signed [16:0] ay_abs;
	cordic_t roll_s1, pitch_s1;
	tag_t    tag_s1;

	cordic_t roll_c  [CORDIC_STAGES+1];
	cordic_t pitch_c [CORDIC_STAGES+1];
	tag_t    tag_q   [CORDIC_STAGES];

	logic signed [ZW-1:0] roll_s2, pitch_s2, pitch_raw;
	tag_t tag_s2;

	div_t dx_c [DIV_STEPS+1];
	div_t dy_c [DIV_STEPS+1];
	logic vld_q [DIV_STEPS+1];

	logic        out_valid_q;
	logic [OUT_W-1:0] axis_x_q, axis_y_q;

	assign en = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_kind_q <= 1'b0;
		end else if (cfg_wen) begin
			pad_kind_q <= cfg_wdata;
		end
	end

	// prep stage: build both vectors
	assign ax = s_axis_tdata[15:0];
	assign ay = s_axis_tdata[31:16];
	assign az = s_axis_tdata[47:32];
	assign ay_abs = ay[15] ? -17'(ay) : 17'(ay);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1.valid      <= s_axis_tvalid;
			tag_s1.kind       <= pad_kind_q;
			tag_s1.roll_zero  <= (ax == 16'sd0) && (ay == 16'sd0);
			tag_s1.pitch_zero <= (ay == 16'sd0) && (az == 16'sd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s1  <= cordic_init(17'(ax), ay_abs);
			pitch_s1 <= cordic_init(17'(az), -17'(ay));
		end
	end

	// CORDIC chains
	assign roll_c[0]  = roll_s1;
	assign pitch_c[0] = pitch_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		tad_cordic_cell u_roll (
			.clk   (clk),
			.en    (en),
			.stage (STAGE_W'(i)),
			.d     (roll_c[i]),
			.q     (roll_c[i+1])
		);
		tad_cordic_cell u_pitch (
			.clk   (clk),
			.en    (en),
			.stage (STAGE_W'(i)),
			.d     (pitch_c[i]),
			.q     (pitch_c[i+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_q[i] <= '0;
			end else if (en) begin
				tag_q[i] <= (i == 0) ? tag_s1 : tag_q[i == 0 ? 0 : i-1];
			end
		end
	end

	// angle stage: zero vectors, base offset, wrap
	always_comb begin
		pitch_raw = pitch_c[CORDIC_STAGES].z - set_base(tag_q[CORDIC_STAGES-1].kind);
		if (pitch_raw > ANG_PI) begin
			pitch_raw = pitch_raw - ANG_TWO_PI;
		end else if (pitch_raw < -ANG_PI) begin
			pitch_raw = pitch_raw + ANG_TWO_PI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_q[CORDIC_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s2  <= tag_q[CORDIC_STAGES-1].roll_zero ? '0 : roll_c[CORDIC_STAGES].z;
			pitch_s2 <= tag_q[CORDIC_STAGES-1].pitch_zero ? '0 : pitch_raw;
		end
	end

	// dead-zone stage feeds the divider chains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= tag_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_c[0] <= dz_setup(roll_s2, tag_s2.kind, 1'b0);
			dy_c[0] <= dz_setup(pitch_s2, tag_s2.kind, 1'b1);
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		tad_div_cell u_dx (
			.clk (clk),
			.en  (en),
			.d   (dx_c[j]),
			.q   (dx_c[j+1])
		);
		tad_div_cell u_dy (
			.clk (clk),
			.en  (en),
			.d   (dy_c[j]),
			.q   (dy_c[j+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j+1] <= 1'b0;
			end else if (en) begin
				vld_q[j+1] <= vld_q[j];
			end
		end
	end

	// sign and saturate
	function automatic logic [OUT_W-1:0] sat_out(input div_t d);
		logic [OUT_W-1:0] r;
		if (d.neg) begin
			r = (d.quo > 19'd262144) ? 19'h40000 : OUT_W'(-d.quo);
		end else begin
			r = (d.quo > 19'd262143) ? 19'h3FFFF : d.quo;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_q[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axis_x_q <= sat_out(dx_c[DIV_STEPS]);
			axis_y_q <= sat_out(dy_c[DIV_STEPS]);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, axis_y_q, axis_x_q};

endmodule
